// File: sv/hrbd_pkg.sv
// Package for the HTTP response body deframer.
// Holds the parser state type, keyword tables and the per-byte step functions.
`default_nettype none
package hrbd_pkg;
	localparam int LEN_W = 32;
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	typedef enum logic [3:0] {
		PH_STATUS = 4'd0, PH_HNAME = 4'd1, PH_HTE = 4'd2, PH_HCL = 4'd3,
		PH_HSKIP = 4'd4, PH_CSIZE = 4'd5, PH_CDATA = 4'd6, PH_CTRAIL = 4'd7,
		PH_FOOTER = 4'd8, PH_FIXED = 4'd9, PH_DONE = 4'd10, PH_ERROR = 4'd11
	} phase_t;

	localparam logic [3:0] NP_WS = 4'd0;
	localparam logic [3:0] NP_SIGN = 4'd1;
	localparam logic [3:0] NP_ZERO = 4'd2;
	localparam logic [3:0] NP_X = 4'd3;
	localparam logic [3:0] NP_DIG = 4'd4;
	localparam logic [3:0] NP_STOP = 4'd5;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_DONE = 2'd1;
	localparam logic [1:0] EV_BAD = 2'd2;

	localparam logic [7:0] KW_TE [17] = '{"T", "r", "a", "n", "s", "f", "e", "r", "-",
		"E", "n", "c", "o", "d", "i", "n", "g"};
	localparam logic [7:0] KW_CL [14] = '{"C", "o", "n", "t", "e", "n", "t", "-",
		"L", "e", "n", "g", "t", "h"};
	localparam logic [7:0] KW_CH [7] = '{"c", "h", "u", "n", "k", "e", "d"};
	localparam logic [7:0] KW_200 [3] = '{"2", "0", "0"};
	localparam logic [7:0] KW_100 [3] = '{"1", "0", "0"};

	typedef struct packed {
		phase_t phase;
		logic [3:0] lpos;
		logic pcr;
		logic lempty;
		logic gok;
		logic [1:0] nmf;
		logic [2:0] kmi;
		logic chunked;
		logic [LEN_W-1:0] acc;
		logic [LEN_W-1:0] blen;
		logic [LEN_W-1:0] brem;
	} st_t;

	typedef struct packed {
		st_t st;
		logic [1:0] ev;
	} step_t;

	typedef struct packed {
		logic body_valid;
		logic [7:0] body_out;
		logic [1:0] event_res;
	} res_t;

	function automatic st_t new_line(st_t s);
		st_t r;
		r = s;
		r.lempty = 1'b1;
		r.lpos = '0;
		r.kmi = '0;
		r.acc = '0;
		r.nmf = 2'b11;
		r.pcr = 1'b0;
		return r;
	endfunction

	function automatic st_t reset_state();
		st_t r;
		r = '0;
		r.phase = PH_STATUS;
		return new_line(r);
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == " ") || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic st_t num_byte(st_t s, logic [7:0] c, logic hex);
		st_t r;
		logic dv;
		logic [3:0] d;
		logic [LEN_W+4:0] prod;
		r = s;
		dv = 1'b0;
		d = '0;
		if (c >= "0" && c <= "9") begin
			dv = 1'b1;
			d = 4'(c - "0");
		end else if (hex && c >= "a" && c <= "f") begin
			dv = 1'b1;
			d = 4'(c - "a" + 8'd10);
		end else if (hex && c >= "A" && c <= "F") begin
			dv = 1'b1;
			d = 4'(c - "A" + 8'd10);
		end
		if (hex)
			prod = {s.acc, 4'b0000} + (LEN_W+5)'(d);
		else
			prod = (LEN_W+5)'({s.acc, 3'b000}) + (LEN_W+5)'({s.acc, 1'b0})
				+ (LEN_W+5)'(d);
		if (s.lpos == NP_WS && is_space(c)) begin
			r = s;
		end else if (s.lpos == NP_WS && (c == "+" || c == "-")) begin
			r.kmi = (c == "-") ? 3'd1 : 3'd0;
			r.lpos = NP_SIGN;
		end else if (s.lpos == NP_ZERO && hex && (c == "x" || c == "X")) begin
			r.lpos = NP_X;
		end else if (s.lpos != NP_STOP && dv) begin
			r.acc = (prod > (LEN_W+5)'(LEN_MAX)) ? LEN_MAX : prod[LEN_W-1:0];
			r.lpos = (hex && c == "0" && (s.lpos == NP_WS || s.lpos == NP_SIGN)) ?
				NP_ZERO : NP_DIG;
		end else begin
			r.lpos = NP_STOP;
		end
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] num_value(st_t s);
		return s.kmi[0] ? (LEN_W'(0) - s.acc) : s.acc;
	endfunction

	function automatic st_t content_byte(st_t s, logic [7:0] c);
		st_t r;
		logic [LEN_W-1:0] p;
		logic [2:0] k;
		r = s;
		p = s.acc;
		k = s.kmi;
		r.lempty = 1'b0;
		unique case (s.phase)
			PH_STATUS: begin
				if (c == " ") begin
					if (s.kmi < 3'd2) r.kmi = s.kmi + 3'd1;
				end else if (s.kmi == 3'd1) begin
					if (!(s.lpos < 4'd3 && c == KW_200[s.lpos[1:0]])) r.nmf[0] = 1'b0;
					if (!(s.lpos < 4'd3 && c == KW_100[s.lpos[1:0]])) r.nmf[1] = 1'b0;
					if (s.lpos < 4'd4) r.lpos = s.lpos + 4'd1;
				end
			end
			PH_HNAME: begin
				if (c == ":") begin
					r.acc = '0;
					r.lpos = NP_WS;
					r.kmi = '0;
					if (s.nmf[0]) r.phase = PH_HTE;
					else if (s.nmf[1]) r.phase = PH_HCL;
					else r.phase = PH_HSKIP;
				end else begin
					if (!(p < LEN_W'(17) && c == KW_TE[p[4:0]])) r.nmf[0] = 1'b0;
					if (!(p < LEN_W'(14) && c == KW_CL[p[3:0]])) r.nmf[1] = 1'b0;
					if (p < LEN_W'(31)) r.acc = p + LEN_W'(1);
				end
			end
			PH_HTE: begin
				if (k < 3'd7 && c == KW_CH[k]) k = k + 3'd1;
				else k = (c == "c") ? 3'd1 : 3'd0;
				r.kmi = k;
				if (k == 3'd7) begin
					r.chunked = 1'b1;
					r.phase = PH_HSKIP;
				end
			end
			PH_HCL: r = num_byte(r, c, 1'b0);
			PH_CSIZE: r = num_byte(r, c, 1'b1);
			default: r = r;
		endcase
		return r;
	endfunction

	function automatic step_t line_end(st_t s);
		step_t r;
		logic [LEN_W-1:0] v;
		r.st = s;
		r.ev = EV_NONE;
		v = num_value(s);
		unique case (s.phase)
			PH_STATUS: begin
				if (!s.lempty) begin
					if (s.kmi == 3'd2 && s.lpos == 4'd3 && s.nmf[0]) begin
						r.st.gok = 1'b1;
						r.st.phase = PH_HNAME;
					end else if (s.kmi == 3'd2 && s.lpos == 4'd3 && s.nmf[1]) begin
						r.st.gok = 1'b0;
						r.st.phase = PH_HNAME;
					end else begin
						r.ev = EV_BAD;
						r.st.phase = PH_ERROR;
					end
				end
			end
			PH_HNAME: begin
				if (s.lempty) begin
					if (!s.gok) begin
						r.st.phase = PH_STATUS;
					end else if (s.chunked) begin
						r.st.phase = PH_CSIZE;
					end else if (s.blen == '0) begin
						r.st.phase = PH_DONE;
						r.ev = EV_DONE;
					end else begin
						r.st.brem = s.blen;
						r.st.phase = PH_FIXED;
					end
				end
			end
			PH_HCL: begin
				r.st.chunked = 1'b0;
				r.st.blen = v;
				r.st.phase = PH_HNAME;
			end
			PH_HTE, PH_HSKIP: r.st.phase = PH_HNAME;
			PH_CSIZE: begin
				if (v == '0) begin
					r.st.phase = PH_FOOTER;
				end else begin
					r.st.brem = v;
					r.st.phase = PH_CDATA;
				end
			end
			PH_CTRAIL: r.st.phase = PH_CSIZE;
			PH_FOOTER: begin
				if (s.lempty) begin
					r.st.phase = PH_DONE;
					r.ev = EV_DONE;
				end
			end
			default: r.st = s;
		endcase
		r.st = new_line(r.st);
		return r;
	endfunction
endpackage
`default_nettype wire

// File: sv/hrbd_in_if.sv
// Input channel of the HTTP response body deframer: one response byte per item.
// Depends on nothing.
`default_nettype none
interface hrbd_in_if;
	logic valid;
	logic ready;
	logic start_response;
	logic [7:0] rx_byte;
	modport source (output valid, output start_response, output rx_byte, input ready);
	modport sink (input valid, input start_response, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: sv/hrbd_out_if.sv
// Output channel of the HTTP response body deframer: one result per item.
// Depends on nothing.
`default_nettype none
interface hrbd_out_if;
	logic valid;
	logic ready;
	logic body_valid;
	logic [7:0] body_out;
	logic [1:0] event_res;
	modport source (output valid, output body_valid, output body_out, output event_res,
		input ready);
	modport sink (input valid, input body_valid, input body_out, input event_res,
		output ready);
endinterface
`default_nettype wire

// File: sv/hrbd_core.sv
// Parser state register and per-byte next-state logic.
// Depends on hrbd_pkg.
`default_nettype none
module hrbd_core import hrbd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire logic start_response,
	input wire logic [7:0] rx_byte,
	output res_t res
);
	st_t st_q;
	st_t s0;
	step_t nx;
	st_t t;

	always_comb begin
		s0 = start_response ? reset_state() : st_q;
		nx.st = s0;
		nx.ev = EV_NONE;
		res.body_valid = 1'b0;
		res.body_out = '0;
		t = s0;
		unique case (s0.phase)
			PH_DONE, PH_ERROR: nx.st = s0;
			PH_FIXED, PH_CDATA: begin
				res.body_valid = 1'b1;
				res.body_out = rx_byte;
				if (s0.brem != '0) t.brem = s0.brem - LEN_W'(1);
				if (t.brem == '0) begin
					if (s0.phase == PH_FIXED) begin
						t.phase = PH_DONE;
						nx.ev = EV_DONE;
					end else begin
						t.phase = PH_CTRAIL;
						t = new_line(t);
					end
				end
				nx.st = t;
			end
			default: begin
				if (s0.pcr) begin
					if (rx_byte == 8'h0a) begin
						nx = line_end(s0);
					end else begin
						t.pcr = 1'b0;
						t = content_byte(t, 8'h0d);
						if (rx_byte == 8'h0d) t.pcr = 1'b1;
						else t = content_byte(t, rx_byte);
						nx.st = t;
					end
				end else if (rx_byte == 8'h0d) begin
					t.pcr = 1'b1;
					nx.st = t;
				end else begin
					nx.st = content_byte(t, rx_byte);
				end
			end
		endcase
		res.event_res = nx.ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= reset_state();
		end else if (accept) begin
			st_q <= nx.st;
		end
	end
endmodule
`default_nettype wire

// File: sv/http_response_body_deframer.sv
// Top level of the HTTP response body deframer: parser core and result register.
// Depends on hrbd_pkg, hrbd_in_if, hrbd_out_if and hrbd_core.
//
//   channel  | dir | payload
//   in_ch    | in  | start_response, rx_byte
//   out_ch   | out | body_valid, body_out, event_res
//
// Each byte is parsed in the cycle it is accepted and its result is registered.
// One byte per cycle is accepted while the result register is empty or being taken.
// A stalled result holds the input off; nothing else stalls the parser.
// Reset puts the parser at the start of a status line with an empty result register.
`default_nettype none
module http_response_body_deframer import hrbd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	hrbd_in_if.sink in_ch,
	hrbd_out_if.source out_ch
);
	logic accept;
	logic vld_q;
	res_t res;
	res_t res_q;

	assign in_ch.ready = !vld_q || out_ch.ready;
	assign accept = in_ch.valid && in_ch.ready;

	hrbd_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.start_response(in_ch.start_response),
		.rx_byte(in_ch.rx_byte),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ch.ready) begin
			vld_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_ch.valid = vld_q;
	assign out_ch.body_valid = res_q.body_valid;
	assign out_ch.body_out = res_q.body_out;
	assign out_ch.event_res = res_q.event_res;
endmodule
`default_nettype wire
